// ===== rtl/sti_pkg.sv =====
`timescale 1ns / 1ps

package sti_pkg;

   // configuration register indexes
   localparam int CSR_INDEX_WIDTH = 3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_START_X = 3'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_START_Y = 3'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_START_Z = 3'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_END_X   = 3'd3;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_END_Y   = 3'd4;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEG_END_Z   = 3'd5;

   // dot product slots
   localparam int DOT_DET = 0;
   localparam int DOT_U   = 1;
   localparam int DOT_V   = 2;
   localparam int DOT_T   = 3;
   localparam int NUM_DOT = 4;

   localparam int PIPE_STAGES     = 8;
   localparam int RSP_TDATA_WIDTH = 8;

   typedef logic [PIPE_STAGES-1:0] stage_mask_type;

endpackage

// ===== rtl/segment_triangle_intersect.sv =====
`timescale 1ns / 1ps

// segment versus triangle hit test, one fixed segment against a triangle stream
// - csr port: write csr_wdata into segment start/end coordinate csr_index when
//   csr_we is high; write only while no triangle is in flight
// - req channel: one beat carries one triangle, nine coordinates of COORD_WIDTH
//   bits, signed fixed point with 8 fraction bits
// - rsp channel: one beat per triangle, bit 0 is the hit flag, in request order
// - pipeline: eight register stages (differences, cross products, cross sums,
//   split dot multiplies, product merge, dot sums, u+v sum, compare)
// - throughput: one triangle per cycle while the rsp side does not stall, set by
//   the fully pipelined multipliers
// - each stage holds its own valid bit, so a stalled rsp side fills the empty
//   stages first and req_tready drops only once every stage holds a beat
// - a stall loses and repeats nothing; the output register holds its beat
// - reset (synchronous, active high) empties the pipeline and clears the
//   segment endpoints to zero
// - a zero determinant (parallel segment, degenerate triangle or zero-length
//   segment) reports no hit; edges, vertices and endpoints count as hits
module segment_triangle_intersect #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // configuration write port
   input  logic                                  csr_we,
   input  logic [sti_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [COORD_WIDTH-1:0]                csr_wdata,
   // triangle stream
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // from bit 0: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
   // vert_c_x, vert_c_y, vert_c_z, zero fill to whole bytes
   input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]    req_tdata,
   // result stream
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // from bit 0: hit, zero fill
   output logic [sti_pkg::RSP_TDATA_WIDTH-1:0]   rsp_tdata
);

   localparam int W   = COORD_WIDTH;
   localparam int DW  = W + 1;        // coordinate difference
   localparam int PW  = 2 * DW;       // cross product term
   localparam int CW  = PW + 1;       // cross product component
   localparam int L   = W + 2;        // low slice of a cross component
   localparam int HW  = CW - L;       // high slice of a cross component
   localparam int LPW = DW + L + 1;   // low partial product
   localparam int HPW = DW + HW;      // high partial product
   localparam int FW  = DW + CW;      // full dot term
   localparam int SW  = FW + 2;       // dot product
   localparam int AW  = SW + 1;       // u + v sum
   localparam int NS  = sti_pkg::PIPE_STAGES;
   localparam int ND  = sti_pkg::NUM_DOT;

   // segment endpoints
   logic signed [W-1:0] seg_start_ff [3];
   logic signed [W-1:0] seg_end_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 3; i++) begin
            seg_start_ff[i] <= '0;
            seg_end_ff[i]   <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            sti_pkg::CSR_SEG_START_X: seg_start_ff[0] <= signed'(csr_wdata);
            sti_pkg::CSR_SEG_START_Y: seg_start_ff[1] <= signed'(csr_wdata);
            sti_pkg::CSR_SEG_START_Z: seg_start_ff[2] <= signed'(csr_wdata);
            sti_pkg::CSR_SEG_END_X:   seg_end_ff[0]   <= signed'(csr_wdata);
            sti_pkg::CSR_SEG_END_Y:   seg_end_ff[1]   <= signed'(csr_wdata);
            sti_pkg::CSR_SEG_END_Z:   seg_end_ff[2]   <= signed'(csr_wdata);
            default: ;   // indexes past the list are dropped
         endcase
      end
   end

   // pipeline flow control: a stage takes a beat when it is empty or moves on
   sti_pkg::stage_mask_type vld_ff;
   sti_pkg::stage_mask_type en;

   always_comb begin
      en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         en[i] = !vld_ff[i] || en[i+1];
      end
   end

   assign req_tready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // unpack the triangle beat
   logic signed [W-1:0] vin [9];

   for (genvar k = 0; k < 9; k++) begin : g_unpack
      assign vin[k] = signed'(req_tdata[k*W +: W]);
   end

   // stage 1: edge, direction and offset vectors
   logic signed [DW-1:0] s1_dir_in [3];
   logic signed [DW-1:0] s1_e1_in  [3];
   logic signed [DW-1:0] s1_e2_in  [3];
   logic signed [DW-1:0] s1_s_in   [3];
   logic signed [DW-1:0] s1_dir_ff [3];
   logic signed [DW-1:0] s1_e1_ff  [3];
   logic signed [DW-1:0] s1_e2_ff  [3];
   logic signed [DW-1:0] s1_s_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s1_dir_in[i] = DW'(seg_end_ff[i]) - DW'(seg_start_ff[i]);
         s1_e1_in[i]  = DW'(vin[3+i]) - DW'(vin[i]);
         s1_e2_in[i]  = DW'(vin[6+i]) - DW'(vin[i]);
         s1_s_in[i]   = DW'(seg_start_ff[i]) - DW'(vin[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         s1_dir_ff <= s1_dir_in;
         s1_e1_ff  <= s1_e1_in;
         s1_e2_ff  <= s1_e2_in;
         s1_s_ff   <= s1_s_in;
      end
   end

   // stage 2: cross product terms, h = dir x e2 and q = s x e1
   logic signed [PW-1:0] s2_hp_in [6];
   logic signed [PW-1:0] s2_qp_in [6];
   logic signed [PW-1:0] s2_hp_ff [6];
   logic signed [PW-1:0] s2_qp_ff [6];
   logic signed [DW-1:0] s2_dir_ff [3];
   logic signed [DW-1:0] s2_e1_ff  [3];
   logic signed [DW-1:0] s2_e2_ff  [3];
   logic signed [DW-1:0] s2_s_ff   [3];

   for (genvar g = 0; g < 3; g++) begin : g_cross
      localparam int J = (g + 1) % 3;
      localparam int K = (g + 2) % 3;
      assign s2_hp_in[2*g]   = PW'(s1_dir_ff[J]) * PW'(s1_e2_ff[K]);
      assign s2_hp_in[2*g+1] = PW'(s1_dir_ff[K]) * PW'(s1_e2_ff[J]);
      assign s2_qp_in[2*g]   = PW'(s1_s_ff[J]) * PW'(s1_e1_ff[K]);
      assign s2_qp_in[2*g+1] = PW'(s1_s_ff[K]) * PW'(s1_e1_ff[J]);
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s2_hp_ff  <= s2_hp_in;
         s2_qp_ff  <= s2_qp_in;
         s2_dir_ff <= s1_dir_ff;
         s2_e1_ff  <= s1_e1_ff;
         s2_e2_ff  <= s1_e2_ff;
         s2_s_ff   <= s1_s_ff;
      end
   end

   // stage 3: cross product components
   logic signed [CW-1:0] s3_h_in [3];
   logic signed [CW-1:0] s3_q_in [3];
   logic signed [CW-1:0] s3_h_ff [3];
   logic signed [CW-1:0] s3_q_ff [3];
   logic signed [DW-1:0] s3_dir_ff [3];
   logic signed [DW-1:0] s3_e1_ff  [3];
   logic signed [DW-1:0] s3_e2_ff  [3];
   logic signed [DW-1:0] s3_s_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s3_h_in[i] = CW'(s2_hp_ff[2*i]) - CW'(s2_hp_ff[2*i+1]);
         s3_q_in[i] = CW'(s2_qp_ff[2*i]) - CW'(s2_qp_ff[2*i+1]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s3_h_ff   <= s3_h_in;
         s3_q_ff   <= s3_q_in;
         s3_dir_ff <= s2_dir_ff;
         s3_e1_ff  <= s2_e1_ff;
         s3_e2_ff  <= s2_e2_ff;
         s3_s_ff   <= s2_s_ff;
      end
   end

   // stage 4: dot product terms, the wide operand cut into a high and low slice
   // det = e1.h, u = s.h, v = dir.q, t = e2.q
   logic signed [DW-1:0]  mul_a [ND][3];
   logic signed [CW-1:0]  mul_b [ND][3];
   logic signed [LPW-1:0] s4_lo_in [ND][3];
   logic signed [HPW-1:0] s4_hi_in [ND][3];
   logic signed [LPW-1:0] s4_lo_ff [ND][3];
   logic signed [HPW-1:0] s4_hi_ff [ND][3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mul_a[sti_pkg::DOT_DET][i] = s3_e1_ff[i];
         mul_b[sti_pkg::DOT_DET][i] = s3_h_ff[i];
         mul_a[sti_pkg::DOT_U][i]   = s3_s_ff[i];
         mul_b[sti_pkg::DOT_U][i]   = s3_h_ff[i];
         mul_a[sti_pkg::DOT_V][i]   = s3_dir_ff[i];
         mul_b[sti_pkg::DOT_V][i]   = s3_q_ff[i];
         mul_a[sti_pkg::DOT_T][i]   = s3_e2_ff[i];
         mul_b[sti_pkg::DOT_T][i]   = s3_q_ff[i];
      end
      for (int d = 0; d < ND; d++) begin
         for (int i = 0; i < 3; i++) begin
            s4_lo_in[d][i] = LPW'(mul_a[d][i]) * LPW'($signed({1'b0, mul_b[d][i][L-1:0]}));
            s4_hi_in[d][i] = HPW'(mul_a[d][i]) * HPW'($signed(mul_b[d][i][CW-1:L]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s4_lo_ff <= s4_lo_in;
         s4_hi_ff <= s4_hi_in;
      end
   end

   // stage 5: merge the slices back into full terms
   logic signed [FW-1:0] s5_prod_in [ND][3];
   logic signed [FW-1:0] s5_prod_ff [ND][3];

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         for (int i = 0; i < 3; i++) begin
            s5_prod_in[d][i] = (FW'(s4_hi_ff[d][i]) <<< L) + FW'(s4_lo_ff[d][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s5_prod_ff <= s5_prod_in;
      end
   end

   // stage 6: dot products
   logic signed [SW-1:0] s6_dot_in [ND];
   logic signed [SW-1:0] s6_dot_ff [ND];

   always_comb begin
      for (int d = 0; d < ND; d++) begin
         s6_dot_in[d] = SW'(s5_prod_ff[d][0]) + SW'(s5_prod_ff[d][1])
                      + SW'(s5_prod_ff[d][2]);
      end
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s6_dot_ff <= s6_dot_in;
      end
   end

   // stage 7: u + v
   logic signed [AW-1:0] s7_uv_in;
   logic signed [AW-1:0] s7_uv_ff;
   logic signed [AW-1:0] s7_det_ff;
   logic signed [AW-1:0] s7_un_ff;
   logic signed [AW-1:0] s7_vn_ff;
   logic signed [AW-1:0] s7_tn_ff;

   assign s7_uv_in = AW'(s6_dot_ff[sti_pkg::DOT_U]) + AW'(s6_dot_ff[sti_pkg::DOT_V]);

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s7_uv_ff  <= s7_uv_in;
         s7_det_ff <= AW'(s6_dot_ff[sti_pkg::DOT_DET]);
         s7_un_ff  <= AW'(s6_dot_ff[sti_pkg::DOT_U]);
         s7_vn_ff  <= AW'(s6_dot_ff[sti_pkg::DOT_V]);
         s7_tn_ff  <= AW'(s6_dot_ff[sti_pkg::DOT_T]);
      end
   end

   // stage 8: range checks of u, v, u + v and t against 0 and det
   // a negative det flips every comparison instead of negating the numerators
   logic det_pos;
   logic det_neg;
   logic pos_ok;
   logic neg_ok;
   logic hit_in;
   logic rsp_hit_ff;

   always_comb begin
      det_neg = s7_det_ff[AW-1];
      det_pos = !s7_det_ff[AW-1] && (s7_det_ff != '0);
      pos_ok  = !s7_un_ff[AW-1] && (s7_un_ff <= s7_det_ff)
             && !s7_vn_ff[AW-1] && (s7_uv_ff <= s7_det_ff)
             && !s7_tn_ff[AW-1] && (s7_tn_ff <= s7_det_ff);
      neg_ok  = (s7_un_ff[AW-1] || (s7_un_ff == '0)) && (s7_un_ff >= s7_det_ff)
             && (s7_vn_ff[AW-1] || (s7_vn_ff == '0)) && (s7_uv_ff >= s7_det_ff)
             && (s7_tn_ff[AW-1] || (s7_tn_ff == '0)) && (s7_tn_ff >= s7_det_ff);
      hit_in  = (det_pos && pos_ok) || (det_neg && neg_ok);
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         rsp_hit_ff <= hit_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = {{(sti_pkg::RSP_TDATA_WIDTH-1){1'b0}}, rsp_hit_ff};

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam int COORD_W = 32;
   localparam int REQ_W = ((9 * COORD_W + 7) / 8) * 8;
   localparam int RANDOM_PHASES = 8;
   localparam int TRIANGLES_PER_PHASE = 106;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int DRAIN_LIMIT = 20000;
   localparam int N_DIRECTED = 23;

   // unmapped register indexes, writes there must leave the segment alone
   localparam logic [sti_pkg::CSR_INDEX_WIDTH-1:0] CSR_RESERVED_A = 3'd6;
   localparam logic [sti_pkg::CSR_INDEX_WIDTH-1:0] CSR_RESERVED_B = 3'd7;
   localparam logic [sti_pkg::CSR_INDEX_WIDTH-1:0] SEG_CSR [6] = '{
      sti_pkg::CSR_SEG_START_X, sti_pkg::CSR_SEG_START_Y, sti_pkg::CSR_SEG_START_Z,
      sti_pkg::CSR_SEG_END_X, sti_pkg::CSR_SEG_END_Y, sti_pkg::CSR_SEG_END_Z
   };

   typedef logic signed [COORD_W-1:0] coord_type;
   // exact products: cubic terms of 33-bit differences stay below 2^101
   typedef logic signed [127:0] wide_type;
   typedef struct {
      wide_type x;
      wide_type y;
      wide_type z;
   } vec3_type;
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   typedef coord_type triangle_type [9];
   // start x, y, z, end x, y, z
   typedef coord_type segment_type [6];

   typedef enum logic [1:0] {WANT_MODEL, WANT_MISS, WANT_HIT} want_type;
   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      bit           reseg;
      segment_type  seg;
      triangle_type vert;
      want_type     want;
   } directed_row_type;

   typedef struct {
      int unsigned beat_no;
      bit          hit;
   } hit_expect_type;

   localparam coord_type ONE = 256;                 // 1.0 in 8 fraction bits
   localparam coord_type MAXC = 32'sh7fff_ffff;
   localparam coord_type MINC = 32'sh8000_0000;

   // dut ports, all inputs known from time zero
   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [sti_pkg::CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [COORD_W-1:0] csr_wdata = '0;
   logic req_tvalid = 1'b0;
   logic req_tready;
   // from bit 0: vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
   // vert_c_x, vert_c_y, vert_c_z
   logic [REQ_W-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   // from bit 0: hit, zero fill
   logic [sti_pkg::RSP_TDATA_WIDTH-1:0] rsp_tdata;

   // segment as the block should hold it
   segment_type seg_regs = '{default: '0};
   hit_expect_type pending_hits[$];
   int unsigned beats_sent = 0;
   int unsigned error_count = 0;

   // flow control knobs, percent of cycles
   int unsigned gap_pct = 0;
   int unsigned stall_pct = 0;
   // long receiver hold, requested by the sequencer and timed by the receiver
   int unsigned hold_asked = 0;
   int unsigned hold_seen = 0;
   int unsigned hold_left = 0;

   // directed rows: reset state, hand-checked geometry on a z segment from -1 to 1,
   // then segments and triangles at the coordinate extremes
   directed_row_type directed_rows [N_DIRECTED] = '{
      // reset segment has zero length, so nothing can hit
      '{1'b0, '{default: '0}, '{-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0}, WANT_MISS},
      '{1'b0, '{default: '0}, '{9{MINC}}, WANT_MISS},
      '{1'b0, '{default: '0}, '{9{MAXC}}, WANT_MISS},
      // segment (0,0,-1) to (0,0,1): plain hit, then reversed winding
      '{1'b1, '{0, 0, -ONE, 0, 0, ONE},
        '{-ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE, 0}, WANT_HIT},
      '{1'b0, '{default: '0}, '{-ONE, -ONE, 0, 0, ONE, 0, ONE, -ONE, 0}, WANT_HIT},
      // crossing exactly on a vertex, then on an edge
      '{1'b0, '{default: '0}, '{0, 0, 0, ONE, 0, 0, 0, ONE, 0}, WANT_HIT},
      '{1'b0, '{default: '0}, '{-ONE, 0, 0, ONE, 0, 0, 0, ONE, 0}, WANT_HIT},
      // plane through the end point, then through the start point
      '{1'b0, '{default: '0},
        '{-ONE, -ONE, ONE, ONE, -ONE, ONE, 0, ONE, ONE}, WANT_HIT},
      '{1'b0, '{default: '0},
        '{-ONE, -ONE, -ONE, ONE, -ONE, -ONE, 0, ONE, -ONE}, WANT_HIT},
      // one lsb beyond either end
      '{1'b0, '{default: '0},
        '{-ONE, -ONE, ONE + 1, ONE, -ONE, ONE + 1, 0, ONE, ONE + 1}, WANT_MISS},
      '{1'b0, '{default: '0},
        '{-ONE, -ONE, -ONE - 1, ONE, -ONE, -ONE - 1, 0, ONE, -ONE - 1}, WANT_MISS},
      // off to the side, and one lsb past an edge
      '{1'b0, '{default: '0},
        '{ONE, -ONE, 0, 3 * ONE, -ONE, 0, 2 * ONE, ONE, 0}, WANT_MISS},
      '{1'b0, '{default: '0}, '{1, -ONE, 0, 1, ONE, 0, ONE, 0, 0}, WANT_MISS},
      // segment lying in the triangle plane: zero determinant
      '{1'b0, '{default: '0}, '{0, -ONE, -ONE, 0, ONE, -ONE, 0, 0, ONE}, WANT_MISS},
      // degenerate triangles: collinear, then collapsed to a point
      '{1'b0, '{default: '0}, '{-ONE, 0, 0, 0, 0, 0, ONE, 0, 0}, WANT_MISS},
      '{1'b0, '{default: '0}, '{9{0}}, WANT_MISS},
      '{1'b0, '{default: '0}, '{MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0}, WANT_MODEL},
      '{1'b0, '{default: '0},
        '{MINC, MAXC, MINC, MAXC, MINC, MAXC, MAXC, MAXC, MINC}, WANT_MODEL},
      // diagonal segment spanning the whole coordinate range
      '{1'b1, '{MINC, MINC, MINC, MAXC, MAXC, MAXC},
        '{-ONE, 0, 0, ONE, -ONE, 0, 0, ONE, ONE}, WANT_MODEL},
      '{1'b0, '{default: '0},
        '{MINC, MAXC, 0, MAXC, MINC, 0, MINC, MINC, MAXC}, WANT_MODEL},
      '{1'b0, '{default: '0},
        '{MINC, MINC, MINC, 0, ONE, -ONE, ONE, 0, -ONE}, WANT_MODEL},
      '{1'b0, '{default: '0},
        '{MAXC, MAXC, MAXC, -ONE, 0, ONE, 0, -ONE, ONE}, WANT_MODEL},
      // mixed extremes, running the other way
      '{1'b1, '{MAXC, MINC, MAXC, MINC, MAXC, MINC},
        '{MINC, MINC, 0, MAXC, MINC, 0, 0, MAXC, 0}, WANT_MODEL}
   };

   segment_triangle_intersect #(
      .COORD_WIDTH(COORD_W)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic vec3_type vec_span(input coord_type hx, input coord_type hy,
                                         input coord_type hz, input coord_type tx,
                                         input coord_type ty, input coord_type tz);
      vec3_type r;
      r.x = wide_type'(hx) - wide_type'(tx);
      r.y = wide_type'(hy) - wide_type'(ty);
      r.z = wide_type'(hz) - wide_type'(tz);
      return r;
   endfunction

   function automatic vec3_type vec_cross(input vec3_type a, input vec3_type b);
      vec3_type r;
      r.x = a.y * b.z - a.z * b.y;
      r.y = a.z * b.x - a.x * b.z;
      r.z = a.x * b.y - a.y * b.x;
      return r;
   endfunction

   function automatic wide_type vec_dot(input vec3_type a, input vec3_type b);
      return a.x * b.x + a.y * b.y + a.z * b.z;
   endfunction

   // moller-trumbore without the divide: u, v, t numerators are compared
   // against 0 and the determinant after folding in the determinant's sign
   function automatic bit segment_crosses(input segment_type seg, input triangle_type t);
      vec3_type dir, e1, e2, s, h, q;
      wide_type det, un, vn, tn;
      dir = vec_span(seg[3], seg[4], seg[5], seg[0], seg[1], seg[2]);
      e1 = vec_span(t[3], t[4], t[5], t[0], t[1], t[2]);
      e2 = vec_span(t[6], t[7], t[8], t[0], t[1], t[2]);
      s = vec_span(seg[0], seg[1], seg[2], t[0], t[1], t[2]);
      h = vec_cross(dir, e2);
      det = vec_dot(e1, h);
      // parallel, zero-length segment or degenerate triangle
      if (det == 0)
         return 1'b0;
      un = vec_dot(s, h);
      q = vec_cross(s, e1);
      vn = vec_dot(dir, q);
      tn = vec_dot(e2, q);
      if (det < 0) begin
         det = -det;
         un = -un;
         vn = -vn;
         tn = -tn;
      end
      // closed intervals: edges, vertices and both endpoints count
      return un >= 0 && un <= det && vn >= 0 && un + vn <= det && tn >= 0 && tn <= det;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   // signed value spread over roughly +/- 2^sc
   function automatic coord_type scaled_rand(input int unsigned sc);
      coord_type r;
      r = $urandom;
      return r >>> (31 - sc);
   endfunction

   // most triangles are built around a point on the segment so that hits,
   // edge and vertex crossings and degenerate cases all show up often
   function automatic void build_triangle(input segment_type seg, output triangle_type t);
      coord_type p [3];
      coord_type o1 [3];
      coord_type o2 [3];
      int unsigned k, sc, pick, i;
      // segment parameter in 1/256 steps, endpoints picked on purpose now and then
      if ($urandom_range(9) == 0)
         k = $urandom_range(1) ? 256 : 0;
      else
         k = $urandom_range(256);
      sc = ($urandom_range(3) == 0) ? $urandom_range(31, 1) : $urandom_range(16, 2);
      pick = $urandom_range(99);
      for (i = 0; i < 3; i++) begin
         p[i] = coord_type'(longint'(seg[i]) +
                (((longint'(seg[3 + i]) - longint'(seg[i])) * longint'(k)) >>> 8));
         o1[i] = scaled_rand(sc);
         o2[i] = scaled_rand(sc);
      end
      for (i = 0; i < 3; i++) begin
         if (pick < 45) begin
            // point on the segment is the centroid: nearly always a hit
            t[i] = p[i] + o1[i];
            t[3 + i] = p[i] + o2[i];
            t[6 + i] = p[i] - o1[i] - o2[i];
         end else if (pick < 65) begin
            // loose triangle near the segment, hit or miss
            t[i] = p[i] + o1[i];
            t[3 + i] = p[i] + o2[i];
            t[6 + i] = p[i] + scaled_rand(sc);
         end else if (pick < 72) begin
            // vertex sitting on the segment
            t[i] = p[i];
            t[3 + i] = p[i] + o1[i];
            t[6 + i] = p[i] + o2[i];
         end else if (pick < 80) begin
            // edge passing through the segment
            t[i] = p[i] - o1[i];
            t[3 + i] = p[i] + o1[i];
            t[6 + i] = p[i] + o2[i];
         end else if (pick < 85) begin
            // collinear vertices
            t[i] = p[i] + o1[i];
            t[3 + i] = p[i] + o2[i];
            t[6 + i] = p[i] + 2 * o2[i] - o1[i];
         end else if (pick < 90) begin
            // repeated vertex
            t[i] = p[i] + o1[i];
            t[3 + i] = p[i] + o1[i];
            t[6 + i] = p[i] + o2[i];
         end else begin
            // noise over the full field range
            t[i] = $urandom;
            t[3 + i] = $urandom;
            t[6 + i] = $urandom;
         end
      end
   endfunction

   function automatic void pick_segment(input int phase, output segment_type seg);
      int unsigned sc, i;
      sc = $urandom_range(31, 8);
      unique case (phase)
         0: for (i = 0; i < 6; i++) seg[i] = scaled_rand(12);
         1: seg = '{MINC, MINC, MINC, MAXC, MAXC, MAXC};
         2: seg = '{MAXC, MINC, MAXC, MINC, MAXC, MINC};
         3: begin
            // axis aligned along x
            for (i = 0; i < 3; i++) seg[i] = scaled_rand(14);
            seg[3] = scaled_rand(14);
            seg[4] = seg[1];
            seg[5] = seg[2];
         end
         default: for (i = 0; i < 6; i++) seg[i] = scaled_rand(sc);
      endcase
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      unique case (mode)
         IDLE_NONE: begin
            gap_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            gap_pct = 45;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            gap_pct = 0;
            stall_pct = 45;
         end
         IDLE_BOTH: begin
            gap_pct = 15;
            stall_pct = 15;
         end
      endcase
   endtask

   task automatic write_csr(input logic [sti_pkg::CSR_INDEX_WIDTH-1:0] idx,
                            input coord_type value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      // unmapped indexes are dropped by the block
      if (idx <= sti_pkg::CSR_SEG_END_Z)
         seg_regs[idx] = value;
   endtask

   // only called with the pipeline empty
   task automatic program_segment(input segment_type seg);
      int i;
      for (i = 0; i < 6; i++)
         write_csr(SEG_CSR[i], seg[i]);
      // junk to the unmapped slots afterwards, must not disturb the segment
      write_csr(CSR_RESERVED_A, $urandom);
      write_csr(CSR_RESERVED_B, $urandom);
      csr_we <= 1'b0;
   endtask

   // offer one triangle beat, return at the edge that takes it
   task automatic offer_triangle(input triangle_type t, input bit hit);
      logic [REQ_W-1:0] word;
      hit_expect_type entry;
      int i;
      word = '0;
      for (i = 0; i < 9; i++)
         word[i * COORD_W +: COORD_W] = t[i];
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= word;
      do @(posedge clock); while (!req_tready);
      entry.beat_no = beats_sent;
      entry.hit = hit;
      pending_hits = {pending_hits, entry};
      beats_sent++;
   endtask

   // stop offering and wait until every hit flag has come back
   task automatic drain_results();
      int waited;
      req_tvalid <= 1'b0;
      waited = 0;
      while (pending_hits.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      // let the pipeline latency pass so a surplus beat would show up
      repeat (sti_pkg::PIPE_STAGES + 4) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- result side

   // random stalls, plus one long hold on request that fills the pipeline
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_seen != hold_asked) begin
         hold_seen <= hold_asked;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // each result beat is checked against the oldest outstanding prediction
   always @(posedge clock) begin
      hit_expect_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_hits.size() == 0) begin
            $error("result beat with no triangle outstanding, hit %0d", rsp_tdata[0]);
            error_count++;
         end else begin
            want = pending_hits.pop_front();
            if (rsp_tdata[0] !== want.hit) begin
               $error("hit mismatch on triangle %0d: expected %0d, actual %0d",
                      want.beat_no, want.hit, rsp_tdata[0]);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequencer

   initial begin : stimulus
      segment_type seg;
      triangle_type t;
      bit hit;
      int r, phase, n;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed rows, with gaps on both sides
      set_idle(IDLE_BOTH);
      for (r = 0; r < N_DIRECTED; r++) begin
         if (directed_rows[r].reseg) begin
            drain_results();
            program_segment(directed_rows[r].seg);
         end
         if (directed_rows[r].want == WANT_MODEL)
            hit = segment_crosses(seg_regs, directed_rows[r].vert);
         else
            hit = (directed_rows[r].want == WANT_HIT);
         offer_triangle(directed_rows[r].vert, hit);
      end

      // random phases, each with its own segment and flow control mix;
      // the drain before each phase is also the sender pause until all results are in
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         pick_segment(phase, seg);
         program_segment(seg);
         set_idle(idle_mode_type'(phase % 4));
         // back-to-back beats against a held receiver: pipeline fills, req stalls
         if (phase == 0)
            hold_asked <= hold_asked + 1;
         for (n = 0; n < TRIANGLES_PER_PHASE; n++) begin
            build_triangle(seg_regs, t);
            offer_triangle(t, segment_crosses(seg_regs, t));
         end
      end

      drain_results();
      if (pending_hits.size() != 0) begin
         $error("%0d hit results never arrived, first from triangle %0d",
                pending_hits.size(), pending_hits[0].beat_no);
         error_count++;
      end
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // hang guard, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
